[hdl/sacl_pkg.sv]
package sacl_pkg;

  localparam int TotalLines = 32;
  localparam int NumWays    = 4;
  localparam int AddrBits   = 32;
  localparam int CountBits  = 32;

  localparam int NumSets  = TotalLines / NumWays;
  localparam int SetW     = $clog2(NumSets);
  localparam int WayW     = $clog2(NumWays);
  localparam int LineOffW = $clog2(TotalLines);
  localparam int TagW     = AddrBits - SetW;
  localparam int AgeW     = WayW;

  typedef logic [SetW-1:0]  set_t;
  typedef logic [WayW-1:0]  way_t;
  typedef logic [TagW-1:0]  tag_t;
  typedef logic [AgeW-1:0]  age_t;

  typedef struct packed {
    logic [NumWays-1:0] valid;
    tag_t [NumWays-1:0] tag;
    age_t [NumWays-1:0] age;
  } row_t;

  typedef struct packed {
    logic hit;
    way_t way;
    row_t row;
  } lookup_t;

  function automatic set_t addr_set(input logic [AddrBits-1:0] a);
    return a[LineOffW +: SetW];
  endfunction

  function automatic tag_t addr_tag(input logic [AddrBits-1:0] a);
    return a[AddrBits-1:SetW];
  endfunction

endpackage

[hdl/sacl_store.sv]
module sacl_store import sacl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  set_t rd_set,
  output row_t rd_row,
  input  logic wr_en,
  input  set_t wr_set,
  input  row_t wr_row
);

  logic [NumWays-1:0] valid [NumSets];
  tag_t [NumWays-1:0] tags  [NumSets];
  age_t [NumWays-1:0] ages  [NumSets];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NumSets; s++) begin
        valid[s] <= '0;
        for (int w = 0; w < NumWays; w++) begin
          ages[s][w] <= AgeW'(NumWays - 1 - w);
        end
      end
    end else if (wr_en) begin
      valid[wr_set] <= wr_row.valid;
      ages[wr_set]  <= wr_row.age;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tags[wr_set] <= wr_row.tag;
    end
  end

  always_comb begin
    rd_row.valid = valid[rd_set];
    rd_row.tag   = tags[rd_set];
    rd_row.age   = ages[rd_set];
  end

endmodule

[hdl/sacl_match.sv]
module sacl_match import sacl_pkg::*; (
  input  row_t    row,
  input  tag_t    tag,
  output lookup_t res
);

  logic hit;
  way_t hit_way;
  way_t victim;
  way_t sel;
  age_t oldest;
  age_t mine;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (row.valid[w] && row.tag[w] == tag) begin
        hit     = 1'b1;
        hit_way = WayW'(w);
      end
    end
  end

  always_comb begin
    oldest = '0;
    victim = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (row.age[w] >= oldest) begin
        oldest = row.age[w];
        victim = WayW'(w);
      end
    end
  end

  assign sel  = hit ? hit_way : victim;
  assign mine = row.age[sel];

  always_comb begin
    res.hit = hit;
    res.way = sel;
    res.row = row;
    for (int w = 0; w < NumWays; w++) begin
      if (WayW'(w) == sel) begin
        res.row.age[w] = '0;
      end else if (row.age[w] < mine) begin
        res.row.age[w] = row.age[w] + 1'b1;
      end
    end
    if (!hit) begin
      res.row.valid[sel] = 1'b1;
      res.row.tag[sel]   = tag;
    end
  end

endmodule

[hdl/sacl_count.sv]
module sacl_count import sacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 hit,
  output logic [CountBits-1:0] hit_count,
  output logic [CountBits-1:0] access_count
);

  localparam logic [CountBits-1:0] CountMax = '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count    <= '0;
      access_count <= '0;
    end else if (step) begin
      if (access_count != CountMax) begin
        access_count <= access_count + 1'b1;
      end
      if (hit && hit_count != CountMax) begin
        hit_count <= hit_count + 1'b1;
      end
    end
  end

endmodule

[hdl/four_way_set_assoc_cache_lookup.sv]
// channel  | signals                                        | handshake
// ---------+------------------------------------------------+-------------------------
// request  | address                                        | start && !busy
// result   | hit, way, set_index, hit_total, access_total   | done, one cycle, no stall
//
// One request per cycle outside reset; a request beat goes into req, then done.
// Each cycle compares the four ways of one set held in flip-flops, picks the
// hit or LRU way and writes the row back, so the next beat sees the update.
// Reset clears valid bits and counters and loads ages 3,2,1,0 per set;
// busy is high only during reset. The receiver cannot stall results.
module four_way_set_assoc_cache_lookup import sacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [AddrBits-1:0]  address,
  output logic                 done,
  output logic                 hit,
  output logic [WayW-1:0]      way,
  output logic [SetW-1:0]      set_index,
  output logic [CountBits-1:0] hit_total,
  output logic [CountBits-1:0] access_total
);

  logic                req;
  logic [AddrBits-1:0] addr;
  set_t                cur_set;
  tag_t                cur_tag;
  row_t                row;
  lookup_t             res;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      req <= 1'b0;
    end else begin
      req <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      addr <= address;
    end
  end

  assign cur_set = addr_set(addr);
  assign cur_tag = addr_tag(addr);

  sacl_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_set (cur_set),
    .rd_row (row),
    .wr_en  (req),
    .wr_set (cur_set),
    .wr_row (res.row)
  );

  sacl_match u_match (
    .row (row),
    .tag (cur_tag),
    .res (res)
  );

  sacl_count u_count (
    .clk          (clk),
    .rst          (rst),
    .step         (req),
    .hit          (res.hit),
    .hit_count    (hit_total),
    .access_count (access_total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      hit       <= res.hit;
      way       <= res.way;
      set_index <= cur_set;
    end
  end

`ifndef SYNTH
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without matching request");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> hit_total <= access_total)
    else $error("hit count exceeds access count");

  a_access_step: assert property (@(posedge clk) disable iff (rst)
    done && $past(!rst) |-> access_total == $past(access_total) + 1'b1 ||
      access_total == '1)
    else $error("access count did not advance");

  a_hit_step: assert property (@(posedge clk) disable iff (rst)
    done && !hit && $past(!rst) |-> hit_total == $past(hit_total))
    else $error("hit count moved on a miss");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench import sacl_pkg::*;;

  localparam int WatchdogLimit = 500;
  localparam int PoolSize      = 20;
  localparam int HotSets       = 4;
  localparam int DirectedLen   = 24;

  typedef struct packed {
    logic                 hit;
    way_t                 way;
    set_t                 set_index;
    logic [CountBits-1:0] hit_total;
    logic [CountBits-1:0] access_total;
  } lookup_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [AddrBits-1:0]  address = '0;
  logic                 busy;
  logic                 done;
  logic                 hit;
  logic [WayW-1:0]      way;
  logic [SetW-1:0]      set_index;
  logic [CountBits-1:0] hit_total;
  logic [CountBits-1:0] access_total;

  logic                 ts_valid [NumSets][NumWays];
  tag_t                 ts_tag   [NumSets][NumWays];
  age_t                 ts_age   [NumSets][NumWays];
  logic [CountBits-1:0] hit_count;
  logic [CountBits-1:0] access_count;

  lookup_beat_t         expected_lookups[$];
  logic [AddrBits-1:0]  line_pool [PoolSize];
  set_t                 hot_sets  [HotSets];
  int                   mismatches = 0;
  int                   stall_cycles = 0;
  bit                   idle_enabled = 1'b0;

  four_way_set_assoc_cache_lookup dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .address     (address),
    .done        (done),
    .hit         (hit),
    .way         (way),
    .set_index   (set_index),
    .hit_total   (hit_total),
    .access_total(access_total)
  );

  always #10 clk = ~clk;

  task automatic reset_tag_store();
    for (int s = 0; s < NumSets; s++) begin
      for (int w = 0; w < NumWays; w++) begin
        ts_valid[s][w] = 1'b0;
        ts_tag[s][w]   = '0;
        ts_age[s][w]   = age_t'(NumWays - 1 - w);
      end
    end
    hit_count    = '0;
    access_count = '0;
  endtask

  function automatic lookup_beat_t lookup_tag_store(input logic [AddrBits-1:0] a);
    lookup_beat_t r;
    set_t         s;
    tag_t         t;
    age_t         mine;
    s = a[LineOffW +: SetW];
    t = a[AddrBits-1:SetW];
    r = '0;
    r.set_index = s;
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (ts_valid[s][w] && ts_tag[s][w] == t) begin
        r.hit = 1'b1;
        r.way = way_t'(w);
      end
    end
    if (r.hit) begin
      if (hit_count != '1) hit_count++;
    end else begin
      for (int w = 0; w < NumWays; w++) begin
        if (ts_age[s][w] == age_t'(NumWays - 1)) r.way = way_t'(w);
      end
      ts_valid[s][r.way] = 1'b1;
      ts_tag[s][r.way]   = t;
    end
    mine = ts_age[s][r.way];
    for (int w = 0; w < NumWays; w++) begin
      if (ts_age[s][w] < mine) ts_age[s][w]++;
    end
    ts_age[s][r.way] = '0;
    if (access_count != '1) access_count++;
    r.hit_total    = hit_count;
    r.access_total = access_count;
    return r;
  endfunction

  task automatic send_access(input logic [AddrBits-1:0] a);
    int gap;
    gap = (idle_enabled && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    start   <= 1'b1;
    address <= a;
    do @(posedge clk); while (busy);
    expected_lookups.push_back(lookup_tag_store(a));
  endtask

  function automatic logic [AddrBits-1:0] random_line();
    logic [AddrBits-1:0] a;
    a = AddrBits'($urandom());
    a[LineOffW +: SetW] = hot_sets[$urandom_range(0, HotSets - 1)];
    return a;
  endfunction

  function automatic logic [AddrBits-1:0] next_address();
    logic [AddrBits-1:0] a;
    int                  k;
    k = $urandom_range(0, 15);
    if (k == 0) return AddrBits'($urandom());
    if (k == 1) line_pool[$urandom_range(0, PoolSize - 1)] = random_line();
    a = line_pool[$urandom_range(0, PoolSize - 1)];
    a[2:0] = 3'($urandom_range(0, 7));
    return a;
  endfunction

  function automatic void reseed_pool();
    for (int i = 0; i < HotSets; i++) hot_sets[i] = set_t'($urandom_range(0, NumSets - 1));
    for (int i = 0; i < PoolSize; i++) line_pool[i] = random_line();
  endfunction

  task automatic test_directed();
    logic [AddrBits-1:0] seq [DirectedLen] = '{
      32'h0000_0000, 32'h0000_0007, 32'h0000_0008, 32'h0000_0100,
      32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h4000_0000,
      32'h0000_0008, 32'h0000_0100, 32'hFFFF_FFFF, 32'hFFFF_FFF8,
      32'h0000_00E0, 32'hFFFF_FFE7, 32'h7FFF_FFE0, 32'hAAAA_AAAA,
      32'h5555_5555, 32'h0000_0020, 32'h0000_0040, 32'h0000_0060,
      32'h0000_0080, 32'h0000_00A0, 32'h0000_00C0, 32'h0000_0018
    };
    idle_enabled = 1'b0;
    foreach (seq[i]) send_access(seq[i]);
  endtask

  task automatic test_random_traffic();
    idle_enabled = 1'b1;
    for (int i = 0; i < 900; i++) begin
      if (i % 300 == 0) reseed_pool();
      send_access(next_address());
    end
  endtask

  task automatic test_back_to_back();
    idle_enabled = 1'b0;
    reseed_pool();
    for (int i = 0; i < 250; i++) send_access(next_address());
  endtask

  always @(posedge clk) begin : check_results
    lookup_beat_t want;
    if (!rst && done) begin
      if (expected_lookups.size() == 0) begin
        $error("result beat with no pending lookup");
        mismatches++;
      end else begin
        want = expected_lookups.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, hit);
          mismatches++;
        end
        if (way !== want.way) begin
          $error("way: expected %0d, actual %0d", want.way, way);
          mismatches++;
        end
        if (set_index !== want.set_index) begin
          $error("set_index: expected %0d, actual %0d", want.set_index, set_index);
          mismatches++;
        end
        if (hit_total !== want.hit_total) begin
          $error("hit_total: expected %0d, actual %0d", want.hit_total, hit_total);
          mismatches++;
        end
        if (access_total !== want.access_total) begin
          $error("access_total: expected %0d, actual %0d", want.access_total, access_total);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WatchdogLimit) begin
      $display("four_way_set_assoc_cache_lookup: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    reset_tag_store();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic();
    test_back_to_back();
    @(negedge clk);
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("four_way_set_assoc_cache_lookup: match");
    end else begin
      $display("four_way_set_assoc_cache_lookup: mismatch");
    end
    $finish;
  end

endmodule
